>>> rtl/mrt_pkg.sv
// shared types, widths and codes of the memory request rate throttle
package mrt_pkg;

	// fixed field widths
	localparam int CORE_W     = 2;
	localparam int IV_W       = 24;
	localparam int POL_W      = 2;
	localparam int CNT_W      = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int NUM_IV     = 4;

	// defaults for the top level parameters
	localparam int DEF_NUM_CORES  = 4;
	localparam int DEF_TIME_WIDTH = 48;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// operation codes of an input beat
	localparam logic OP_REQUEST = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	// throttling policies
	localparam logic [POL_W-1:0] POL_STRICT  = 2'd0;
	localparam logic [POL_W-1:0] POL_AVERAGE = 2'd1;
	localparam logic [POL_W-1:0] POL_TOKEN   = 2'd2;
	localparam logic [POL_W-1:0] POL_RESET   = POL_TOKEN;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_POLICY    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL0 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL3 = 3'd4;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_COUNT,
		ST_MUL,
		ST_AVG,
		ST_SPACE,
		ST_TOKEN,
		ST_DIV,
		ST_TGAIN,
		ST_TADV,
		ST_DONE
	} state_t;

	// handshake between sequencer and divider
	typedef struct packed {
		logic start;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_rsp_t;

endpackage

>>> rtl/mrt_div.sv
// serial restoring divider: one quotient bit per cycle
module mrt_div #(
	parameter int TIME_WIDTH = mrt_pkg::DEF_TIME_WIDTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  mrt_pkg::div_req_t        req,
	input  logic [TIME_WIDTH-1:0]    dividend,
	input  logic [mrt_pkg::IV_W-1:0] divisor,
	output mrt_pkg::div_rsp_t        rsp,
	output logic [TIME_WIDTH-1:0]    quotient,
	output logic [mrt_pkg::IV_W-1:0] remainder
);

	localparam int IV_W   = mrt_pkg::IV_W;
	localparam int STEP_W = $clog2(TIME_WIDTH + 1);

	logic                busy_q;
	logic                done_q;
	logic [STEP_W-1:0]   step_q;
	logic [TIME_WIDTH-1:0] dq_q;
	logic [IV_W-1:0]     rem_q;
	logic [IV_W-1:0]     div_q;

	logic [IV_W:0] trial;
	logic [IV_W:0] diff;
	logic          ge;

	// trial subtraction of the shifted partial remainder
	always_comb begin
		trial = {rem_q, dq_q[TIME_WIDTH-1]};
		ge    = trial >= {1'b0, div_q};
		diff  = trial - {1'b0, div_q};
	end

	// control: step counter, busy and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(TIME_WIDTH);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: dividend shifts out the top, quotient bits shift in below
	always_ff @(posedge clk) begin
		if (req.start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			dq_q  <= {dq_q[TIME_WIDTH-2:0], ge};
			rem_q <= ge ? diff[IV_W-1:0] : trial[IV_W-1:0];
		end
	end

	assign rsp.busy  = busy_q;
	assign rsp.done  = done_q;
	assign quotient  = dq_q;
	assign remainder = rem_q;

endmodule

>>> rtl/memory_request_rate_throttle_top.sv
// top level of the memory request rate throttle: sequencer, per-core state, output register
//
// Schedules cache miss requests per core under a strict, average-triggered or token
// bucket policy and returns the cycle at which each request may issue; an epoch restart
// beat is taken in the idle state and gives no result. A request holds the input side
// (stall high) while it is worked on. An unthrottled request, or one under the unused
// policy code, goes from the count state to the final state. A strict request passes the
// count, spacing and final states; an average-policy request passes count, multiply,
// average check, spacing when it is spaced, and final. A token-policy request may wait on
// the serial divider, one quotient bit per cycle, to turn elapsed time into earned tokens.
// A result that finds the output register full and stalled waits in the final state and
// takes that much longer. The input side reopens the cycle after the result is loaded, so
// the output register lets the next request be taken while a result still waits. The user
// must write intervals and the policy only while the block is idle; nothing enforces it.
module memory_request_rate_throttle_top #(
	parameter int NUM_CORES  = mrt_pkg::DEF_NUM_CORES,
	parameter int TIME_WIDTH = mrt_pkg::DEF_TIME_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration port
	input  logic                           cfg_write,
	input  logic [mrt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mrt_pkg::CFG_DATA_W-1:0] cfg_data,
	// input channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           operation,
	input  logic [mrt_pkg::CORE_W-1:0]     core,
	input  logic [TIME_WIDTH-1:0]          request_time,
	input  logic [TIME_WIDTH-1:0]          now,
	// output channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [TIME_WIDTH-1:0]          issue_time,
	output logic                           delayed
);

	localparam int IV_W   = mrt_pkg::IV_W;
	localparam int CNT_W  = mrt_pkg::CNT_W;
	localparam int CIDX_W = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
	localparam int PROD_W = CNT_W + IV_W;
	localparam int CMP_W  = (PROD_W > TIME_WIDTH) ? PROD_W : TIME_WIDTH;
	localparam int SUM_W  = TIME_WIDTH + 1;

	// saturating time sum
	function automatic logic [TIME_WIDTH-1:0] sat_add(input logic [TIME_WIDTH-1:0] a,
	                                                  input logic [IV_W-1:0] b);
		logic [TIME_WIDTH:0] s;
		s = {1'b0, a} + (TIME_WIDTH + 1)'(b);
		return s[TIME_WIDTH] ? {TIME_WIDTH{1'b1}} : s[TIME_WIDTH-1:0];
	endfunction

	// configuration registers
	logic [mrt_pkg::POL_W-1:0] policy_q;
	logic [IV_W-1:0]           interval_q [mrt_pkg::NUM_IV];

	// per-core state
	logic [CNT_W-1:0]      req_count_q   [NUM_CORES];
	logic [TIME_WIDTH-1:0] next_allow_q  [NUM_CORES];
	logic [TIME_WIDTH-1:0] token_last_q  [NUM_CORES];
	logic [CNT_W-1:0]      token_count_q [NUM_CORES];
	logic [TIME_WIDTH-1:0] epoch_start_q;

	// request being worked on
	mrt_pkg::state_t       state_q, state_d;
	logic [mrt_pkg::CORE_W-1:0] core_q;
	logic [TIME_WIDTH-1:0] t_q;
	logic [TIME_WIDTH-1:0] now_q;
	logic [TIME_WIDTH-1:0] issue_q;
	logic [PROD_W-1:0]     prod_q;
	logic [TIME_WIDTH-1:0] elapsed_q;

	// output register
	logic                  out_valid_q;
	logic [TIME_WIDTH-1:0] issue_time_q;
	logic                  delayed_q;

	// divider link
	mrt_pkg::div_req_t     div_req;
	mrt_pkg::div_rsp_t     div_rsp;
	logic [TIME_WIDTH-1:0] div_quot;
	logic [IV_W-1:0]       div_rem;

	// control from the output block
	logic load_out;

	// views of the selected core
	logic                  in_accept;
	logic                  core_ok;
	logic [CIDX_W-1:0]     cidx;
	logic [IV_W-1:0]       iv;
	logic [TIME_WIDTH-1:0] na_cur;
	logic [TIME_WIDTH-1:0] tl_cur;
	logic [CNT_W-1:0]      rc_cur;
	logic [CNT_W-1:0]      tc_cur;
	logic [SUM_W-1:0]      tok_sum;
	logic [CNT_W-1:0]      tok_sat;
	logic [2:0]            iv_sel;

	assign in_accept = in_valid && !in_stall;
	assign core_ok   = int'(core_q) < NUM_CORES;
	assign cidx      = core_q[CIDX_W-1:0];
	assign iv        = interval_q[core_q];
	assign na_cur    = next_allow_q[cidx];
	assign tl_cur    = token_last_q[cidx];
	assign rc_cur    = req_count_q[cidx];
	assign tc_cur    = token_count_q[cidx];
	assign iv_sel    = cfg_index - mrt_pkg::REG_INTERVAL0;

	// token gain with saturation at the count limit
	always_comb begin
		tok_sum = SUM_W'(tc_cur) + SUM_W'(div_quot);
		tok_sat = (tok_sum > SUM_W'(mrt_pkg::CNT_MAX)) ? mrt_pkg::CNT_MAX
		                                               : tok_sum[CNT_W-1:0];
	end

	mrt_div #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (t_q - tl_cur),
		.divisor  (iv),
		.rsp      (div_rsp),
		.quotient (div_quot),
		.remainder(div_rem)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mrt_pkg::ST_IDLE: begin
				if (in_accept && operation == mrt_pkg::OP_REQUEST) state_d = mrt_pkg::ST_COUNT;
			end
			mrt_pkg::ST_COUNT: begin
				if (!core_ok || iv == '0) state_d = mrt_pkg::ST_DONE;
				else begin
					case (policy_q)
						mrt_pkg::POL_STRICT:  state_d = mrt_pkg::ST_SPACE;
						mrt_pkg::POL_AVERAGE: state_d = mrt_pkg::ST_MUL;
						mrt_pkg::POL_TOKEN:   state_d = mrt_pkg::ST_TOKEN;
						default:              state_d = mrt_pkg::ST_DONE;
					endcase
				end
			end
			mrt_pkg::ST_MUL: state_d = mrt_pkg::ST_AVG;
			mrt_pkg::ST_AVG: begin
				state_d = (CMP_W'(prod_q) > CMP_W'(elapsed_q)) ? mrt_pkg::ST_SPACE
				                                               : mrt_pkg::ST_DONE;
			end
			mrt_pkg::ST_SPACE: state_d = mrt_pkg::ST_DONE;
			mrt_pkg::ST_TOKEN: begin
				state_d = (tl_cur < t_q) ? mrt_pkg::ST_DIV : mrt_pkg::ST_TADV;
			end
			mrt_pkg::ST_DIV: begin
				if (div_rsp.done) state_d = mrt_pkg::ST_TGAIN;
			end
			mrt_pkg::ST_TGAIN: begin
				state_d = (tok_sat != '0) ? mrt_pkg::ST_DONE : mrt_pkg::ST_TADV;
			end
			mrt_pkg::ST_TADV: state_d = mrt_pkg::ST_DONE;
			mrt_pkg::ST_DONE: begin
				if (load_out) state_d = mrt_pkg::ST_IDLE;
			end
			default: state_d = mrt_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_stall      = 1'b1;
		div_req.start = 1'b0;
		load_out      = 1'b0;
		case (state_q)
			mrt_pkg::ST_IDLE:  in_stall = 1'b0;
			mrt_pkg::ST_TOKEN: div_req.start = tl_cur < t_q;
			mrt_pkg::ST_DONE:  load_out = !out_valid_q || !out_stall;
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mrt_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= mrt_pkg::POL_RESET;
			for (int i = 0; i < mrt_pkg::NUM_IV; i++) interval_q[i] <= '0;
		end else if (cfg_write) begin
			if (cfg_index == mrt_pkg::REG_POLICY) begin
				policy_q <= cfg_data[mrt_pkg::POL_W-1:0];
			end else if (cfg_index inside {[mrt_pkg::REG_INTERVAL0:mrt_pkg::REG_INTERVAL3]}) begin
				interval_q[iv_sel[1:0]] <= cfg_data[IV_W-1:0];
			end
		end
	end

	// per-core state updates and epoch restart
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CORES; i++) begin
				req_count_q[i]   <= '0;
				next_allow_q[i]  <= '0;
				token_last_q[i]  <= '0;
				token_count_q[i] <= '0;
			end
			epoch_start_q <= '0;
		end else begin
			case (state_q)
				mrt_pkg::ST_IDLE: begin
					if (in_accept && operation == mrt_pkg::OP_RESTART) begin
						for (int i = 0; i < NUM_CORES; i++) begin
							req_count_q[i]   <= '0;
							token_count_q[i] <= '0;
							token_last_q[i]  <= now;
						end
						epoch_start_q <= now;
					end
				end
				mrt_pkg::ST_COUNT: begin
					if (core_ok && rc_cur != mrt_pkg::CNT_MAX) req_count_q[cidx] <= rc_cur + 1'b1;
				end
				mrt_pkg::ST_SPACE: begin
					next_allow_q[cidx] <= (na_cur > t_q) ? sat_add(na_cur, iv) : sat_add(t_q, iv);
				end
				mrt_pkg::ST_TGAIN: begin
					if (tok_sat != '0) begin
						token_count_q[cidx] <= tok_sat - 1'b1;
						token_last_q[cidx]  <= t_q - TIME_WIDTH'(div_rem);
					end else begin
						token_count_q[cidx] <= '0;
					end
				end
				mrt_pkg::ST_TADV: token_last_q[cidx] <= sat_add(tl_cur, iv);
				default: begin
					epoch_start_q <= epoch_start_q;
				end
			endcase
		end
	end

	// request datapath: latch, product, issue time
	always_ff @(posedge clk) begin
		case (state_q)
			mrt_pkg::ST_IDLE: begin
				if (in_accept) begin
					core_q <= core;
					t_q    <= request_time;
					now_q  <= now;
				end
			end
			mrt_pkg::ST_COUNT: issue_q <= t_q;
			mrt_pkg::ST_MUL: begin
				prod_q    <= PROD_W'(rc_cur) * PROD_W'(iv);
				elapsed_q <= now_q - epoch_start_q;
			end
			mrt_pkg::ST_SPACE: issue_q <= (na_cur > t_q) ? na_cur : t_q;
			mrt_pkg::ST_TGAIN: issue_q <= t_q;
			mrt_pkg::ST_TADV:  issue_q <= sat_add(tl_cur, iv);
			default: begin
				issue_q <= issue_q;
			end
		endcase
	end

	// output register load
	always_ff @(posedge clk) begin
		if (load_out) begin
			issue_time_q <= issue_q;
			delayed_q    <= issue_q > t_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign issue_time = issue_time_q;
	assign delayed    = delayed_q;

`ifndef NO_ASSERTIONS
	// a taken request holds the input side on the next cycle
	a_req_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && operation == mrt_pkg::OP_REQUEST |=> in_stall)
		else $error("request beat taken but input not stalled");

	// divider finishes only while the sequencer waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == mrt_pkg::ST_DIV)
		else $error("divider done outside of its wait state");

	// a new result comes only from the final state
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == mrt_pkg::ST_DONE))
		else $error("result appeared without the final state");

	// the divider is never restarted while busy
	a_div_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.busy |-> !div_req.start)
		else $error("divider started while busy");
`endif

endmodule

>>> bench/mrt_checker.sv
`timescale 1ns / 100ps
// checker of the rate throttle: mirrors the registers, predicts issue times, compares result beats
module mrt_checker
	import mrt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic                  operation,
	input  logic [CORE_W-1:0]     core,
	input  logic [DEF_TIME_WIDTH-1:0] request_time,
	input  logic [DEF_TIME_WIDTH-1:0] now,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic [DEF_TIME_WIDTH-1:0] issue_time,
	input  logic                  delayed,
	output int                    fail_count,
	output int                    pending
);

	localparam int TW = DEF_TIME_WIDTH;
	typedef logic [TW-1:0] stamp_t;
	localparam stamp_t STAMP_MAX = '1;

	typedef struct packed {
		stamp_t issue;
		logic   late;
	} grant_t;

	// mirrored registers
	logic [POL_W-1:0] policy_m;
	logic [IV_W-1:0]  gap_m [NUM_IV];

	// per-core throttle state
	logic [CNT_W-1:0] req_seen [NUM_IV];
	stamp_t           next_free [NUM_IV];
	stamp_t           bucket_mark [NUM_IV];
	logic [CNT_W-1:0] bucket_tokens [NUM_IV];
	stamp_t           epoch_mark;

	// issue slots granted but not yet seen on the output
	grant_t grant_q [$];

	// time sum clamped at the largest stamp
	function automatic stamp_t sat_time(stamp_t a, logic [IV_W-1:0] b);
		logic [TW:0] s;
		s = {1'b0, a} + b;
		return s[TW] ? STAMP_MAX : s[TW-1:0];
	endfunction

	// spacing shared by strict and average policies
	function automatic stamp_t space_request(int c, stamp_t t, logic [IV_W-1:0] iv);
		stamp_t issue;
		if (next_free[c] > t) begin
			issue = next_free[c];
			next_free[c] = sat_time(next_free[c], iv);
		end else begin
			issue = t;
			next_free[c] = sat_time(t, iv);
		end
		return issue;
	endfunction

	// token bucket: one token per whole interval, remainder carried forward
	function automatic stamp_t take_token(int c, stamp_t t, logic [IV_W-1:0] iv);
		stamp_t      since;
		stamp_t      rem;
		logic [63:0] earned;
		logic [63:0] total;
		if (bucket_mark[c] < t) begin
			since = t - bucket_mark[c];
			rem = since % iv;
			earned = since / iv;
			total = bucket_tokens[c] + earned;
			if (earned > CNT_MAX || total > CNT_MAX)
				total = CNT_MAX;
			bucket_tokens[c] = total[CNT_W-1:0];
			if (bucket_tokens[c] != 0) begin
				bucket_tokens[c] = bucket_tokens[c] - 1'b1;
				bucket_mark[c] = t - rem;
				return t;
			end
		end
		bucket_mark[c] = sat_time(bucket_mark[c], iv);
		return bucket_mark[c];
	endfunction

	// issue slot of one request beat
	function automatic grant_t grant_for(logic [CORE_W-1:0] c, stamp_t t, stamp_t nw);
		logic [IV_W-1:0] iv;
		stamp_t          issue;
		stamp_t          elapsed;
		logic [63:0]     owed;
		grant_t          g;
		iv = gap_m[c];
		issue = t;
		if (req_seen[c] != CNT_MAX)
			req_seen[c] = req_seen[c] + 1'b1;
		if (iv != 0) begin
			case (policy_m)
				POL_STRICT: issue = space_request(c, t, iv);
				POL_AVERAGE: begin
					elapsed = nw - epoch_mark;
					owed = req_seen[c] * iv;
					if (owed > elapsed)
						issue = space_request(c, t, iv);
				end
				POL_TOKEN: issue = take_token(c, t, iv);
				default: ;
			endcase
		end
		g.issue = issue;
		g.late = issue > t;
		return g;
	endfunction

	// watch both channels and the register port
	always @(posedge clk or negedge arst_n) begin : watch
		grant_t want;
		int     i;
		if (!arst_n) begin
			policy_m = POL_RESET;
			for (i = 0; i < NUM_IV; i++) begin
				gap_m[i] = '0;
				req_seen[i] = '0;
				next_free[i] = '0;
				bucket_mark[i] = '0;
				bucket_tokens[i] = '0;
			end
			epoch_mark = '0;
			grant_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			// result beat against the oldest granted slot
			if (out_valid && !out_stall) begin
				if (grant_q.size() == 0) begin
					$display("%0t: unexpected result beat: expected none, actual issue_time %0d delayed %0d",
						$time, issue_time, delayed);
					fail_count++;
				end else begin
					want = grant_q.pop_front();
					if (issue_time !== want.issue) begin
						$display("%0t: issue_time mismatch: expected %0d actual %0d",
							$time, want.issue, issue_time);
						fail_count++;
					end
					if (delayed !== want.late) begin
						$display("%0t: delayed mismatch: expected %0d actual %0d",
							$time, want.late, delayed);
						fail_count++;
					end
				end
			end
			// input beat: epoch restart or request
			if (in_valid && !in_stall) begin
				if (operation == OP_RESTART) begin
					for (i = 0; i < NUM_IV; i++) begin
						req_seen[i] = '0;
						bucket_tokens[i] = '0;
						bucket_mark[i] = now;
					end
					epoch_mark = now;
				end else begin
					want = grant_for(core, request_time, now);
					grant_q.insert(grant_q.size(), want);
				end
			end
			// register writes
			if (cfg_write) begin
				if (cfg_index == REG_POLICY)
					policy_m = cfg_data[POL_W-1:0];
				else if (cfg_index >= REG_INTERVAL0 && cfg_index <= REG_INTERVAL3)
					gap_m[cfg_index - REG_INTERVAL0] = cfg_data[IV_W-1:0];
			end
			pending = grant_q.size();
		end
	end

endmodule

>>> bench/tb_memory_request_rate_throttle_top.sv
`timescale 1ns / 100ps
// testbench top of the rate throttle: clock, reset, beat stimulus, receiver stalls and verdict
module tb_memory_request_rate_throttle_top;
	import mrt_pkg::*;

	localparam int TW = DEF_TIME_WIDTH;
	typedef logic [TW-1:0] stamp_t;
	localparam stamp_t STAMP_MAX = '1;
	localparam logic [IV_W-1:0] IV_MAX = '1;
	localparam logic [POL_W-1:0] POL_UNKNOWN = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
	localparam int TAIL_CYCLES = TW + 12;
	localparam int PHASES = 10;
	localparam int PHASE_BEATS = 75;

	typedef enum int {
		STALL_NONE,
		STALL_RANDOM,
		STALL_PERIODIC,
		STALL_RUNS
	} stall_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  operation = OP_REQUEST;
	logic [CORE_W-1:0]     core = '0;
	stamp_t                request_time = '0;
	stamp_t                now = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	stamp_t                issue_time;
	logic                  delayed;

	int     fail_count;
	int     pending;
	stamp_t clock_base = '0;

	memory_request_rate_throttle_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.core         (core),
		.request_time (request_time),
		.now          (now),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.issue_time   (issue_time),
		.delayed      (delayed)
	);

	mrt_checker grant_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.core         (core),
		.request_time (request_time),
		.now          (now),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.issue_time   (issue_time),
		.delayed      (delayed),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// receiver stalls, switching between patterns
	stall_mode_t stall_mode = STALL_NONE;
	int          mode_left = 0;
	int          run_left = 0;
	always @(negedge clk) begin
		if (mode_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			mode_left = $urandom_range(40, 400);
		end else begin
			mode_left = mode_left - 1;
		end
		case (stall_mode)
			STALL_NONE: out_stall = 1'b0;
			STALL_RANDOM: out_stall = ($urandom_range(0, 2) == 0);
			STALL_PERIODIC: out_stall = (mode_left % 4 == 1);
			default: begin
				if (run_left == 0) begin
					out_stall = ~out_stall;
					run_left = out_stall ? $urandom_range(3, 40) : $urandom_range(1, 12);
				end else begin
					run_left = run_left - 1;
				end
			end
		endcase
	end

	function automatic stamp_t rand_stamp();
		return TW'({$urandom(), $urandom()});
	endfunction

	// interval mix: unthrottled, extremes, small, medium and random spacing
	function automatic logic [IV_W-1:0] rand_gap();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return '0;
		else if (pick == 1)
			return 1;
		else if (pick == 2)
			return IV_MAX;
		else if (pick < 7)
			return IV_W'($urandom_range(2, 40));
		else if (pick < 9)
			return IV_W'($urandom_range(41, 600));
		return IV_W'($urandom());
	endfunction

	// one input beat, held until taken
	task automatic send_beat(input logic op, input logic [CORE_W-1:0] c,
			input stamp_t t, input stamp_t nw);
		@(negedge clk);
		operation = op;
		core = c;
		request_time = t;
		now = nw;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// sender gap with junk on the payload; in_valid stays low for the gap
	task automatic idle_input(input int n);
		@(negedge clk);
		in_valid = 1'b0;
		operation = 1'($urandom_range(0, 1));
		core = CORE_W'($urandom_range(0, 3));
		request_time = rand_stamp();
		now = rand_stamp();
		repeat (n - 1)
			@(negedge clk);
	endtask

	// hold the sender until every granted slot has come out
	task automatic wait_idle();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic settle();
		wait_idle();
		repeat (TAIL_CYCLES)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_write = 1'b0;
	endtask

	// policy with junk in the upper data bits, then all four intervals
	task automatic set_config(input logic [POL_W-1:0] pol, input logic [IV_W-1:0] g0,
			input logic [IV_W-1:0] g1, input logic [IV_W-1:0] g2, input logic [IV_W-1:0] g3);
		logic [CFG_DATA_W-POL_W-1:0] upper;
		upper = (CFG_DATA_W - POL_W)'($urandom());
		settle();
		write_reg(REG_POLICY, {upper, pol});
		write_reg(REG_INTERVAL0, g0);
		write_reg(REG_INTERVAL0 + 3'd1, g1);
		write_reg(REG_INTERVAL0 + 3'd2, g2);
		write_reg(REG_INTERVAL3, g3);
	endtask

	// mostly a steady clock with requests just ahead of it, some behind it, some wild stamps
	task automatic random_beat();
		logic              op;
		logic [CORE_W-1:0] c;
		stamp_t            t;
		stamp_t            nw;
		int                pick;
		clock_base = clock_base + $urandom_range(0, 40);
		op = ($urandom_range(0, 99) < 7) ? OP_RESTART : OP_REQUEST;
		c = CORE_W'($urandom_range(0, 3));
		nw = clock_base;
		t = clock_base + $urandom_range(0, 24);
		pick = $urandom_range(0, 99);
		if (pick < 4)
			t = rand_stamp();
		else if (pick < 8)
			nw = rand_stamp();
		else if (pick < 14)
			t = clock_base - $urandom_range(0, 300);
		send_beat(op, c, t, nw);
	endtask

	// limit on the whole run
	initial begin
		#7_200_000;
		$display("tb_memory_request_rate_throttle_top: FAIL");
		$finish;
	end

	initial begin : stimulus
		int               ph;
		int               sent;
		int               burst;
		int               pick;
		logic [POL_W-1:0] pol;

		repeat (12)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset values: token policy, every core unthrottled, request at time zero
		send_beat(OP_REQUEST, 0, '0, '0);
		send_beat(OP_RESTART, 3, STAMP_MAX, 100);

		// strict spacing, saturation near the top of time, unthrottled core
		set_config(POL_STRICT, 10, 1, IV_MAX, 0);
		write_reg(REG_SPARE, '1);
		send_beat(OP_REQUEST, 0, 0, 0);
		send_beat(OP_REQUEST, 0, 5, 5);
		send_beat(OP_REQUEST, 0, 50, 50);
		send_beat(OP_REQUEST, 2, STAMP_MAX - 5, STAMP_MAX - 5);
		send_beat(OP_REQUEST, 2, STAMP_MAX - 3, STAMP_MAX - 3);
		send_beat(OP_REQUEST, 1, STAMP_MAX, STAMP_MAX);
		send_beat(OP_REQUEST, 3, 123, 123);

		// unknown policy code passes requests through
		set_config(POL_UNKNOWN, 10, 1, IV_MAX, 0);
		send_beat(OP_REQUEST, 0, 7, 7);

		// average policy, including now before the epoch start
		set_config(POL_AVERAGE, 10, 1, IV_MAX, 0);
		send_beat(OP_RESTART, 0, 0, 1000);
		send_beat(OP_REQUEST, 1, 1000, 1000);
		send_beat(OP_REQUEST, 1, 1001, 2000);
		send_beat(OP_REQUEST, 0, 600, 500);

		// token bucket: saturated gain, request behind the bucket mark, remainder kept
		set_config(POL_TOKEN, 1, 100, IV_MAX, 0);
		send_beat(OP_REQUEST, 0, STAMP_MAX, 0);
		send_beat(OP_REQUEST, 1, 500, 500);
		send_beat(OP_REQUEST, 1, 1050, 1050);
		send_beat(OP_REQUEST, 1, 5000, 5000);
		send_beat(OP_REQUEST, 1, 5055, 5055);
		send_beat(OP_REQUEST, 2, 2000, 2000);
		send_beat(OP_RESTART, 2, 0, STAMP_MAX);
		send_beat(OP_REQUEST, 1, 0, 0);

		// random phases, one setting each
		for (ph = 0; ph < PHASES; ph++) begin
			case (ph % 4)
				0: pol = POL_STRICT;
				1: pol = POL_AVERAGE;
				2: pol = POL_TOKEN;
				default: pol = (ph == 3) ? POL_UNKNOWN : POL_TOKEN;
			endcase
			set_config(pol, rand_gap(), rand_gap(), rand_gap(), rand_gap());
			if (ph == 5 || ph == 6)
				clock_base = STAMP_MAX - $urandom_range(0, 20000);
			else if (ph == 7)
				clock_base = '0;
			send_beat(OP_RESTART, CORE_W'($urandom_range(0, 3)), rand_stamp(), clock_base);
			sent = 0;
			while (sent < PHASE_BEATS) begin
				burst = $urandom_range(1, 12);
				repeat (burst) begin
					random_beat();
					sent++;
				end
				pick = $urandom_range(0, 99);
				if (pick < 3)
					wait_idle();
				else if (pick < 60)
					idle_input($urandom_range(1, 15));
			end
		end

		settle();
		if (fail_count == 0 && pending == 0)
			$display("tb_memory_request_rate_throttle_top: PASS");
		else
			$display("tb_memory_request_rate_throttle_top: FAIL");
		$finish;
	end

endmodule

>>> files.f
rtl/mrt_pkg.sv
rtl/mrt_div.sv
rtl/memory_request_rate_throttle_top.sv
bench/mrt_checker.sv
bench/tb_memory_request_rate_throttle_top.sv
